>>> rtl/core/skte_pkg.sv
// Package: sorted key table engine types and constants.
package skte_pkg;

    localparam int DEPTH      = 16;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;
    localparam int AW         = $clog2(2 * DEPTH);
    localparam int PW         = $clog2(DEPTH);
    localparam int CW         = $clog2(DEPTH + 1);

    typedef enum logic [3:0] {
        CMD_LOOKUP  = 4'd0,
        CMD_INSERT  = 4'd1,
        CMD_UPDATE  = 4'd2,
        CMD_DEL_KEY = 4'd3,
        CMD_DEL_1ST = 4'd4,
        CMD_TRUNC   = 4'd5,
        CMD_SWAP    = 4'd6,
        CMD_RD_IDX  = 4'd7,
        CMD_COUNT   = 4'd8
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NOTFOUND = 3'd1,
        ST_DUP      = 3'd2,
        ST_FULL     = 3'd3,
        ST_SWAP_REF = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        CFG_DESC   = 2'd0,
        CFG_SIGNED = 2'd1,
        CFG_DBANK  = 2'd2,
        CFG_CAP    = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRD,
        S_SCMP,
        S_DECIDE,
        S_RDREC,
        S_RDWAIT,
        S_SHRD,
        S_SHWR,
        S_WRNEW,
        S_DONE
    } state_t;

endpackage

>>> rtl/core/skte_ram.sv
// Generic single-port RAM with registered read.
module skte_ram #(
    parameter int WIDTH = 32,
    parameter int ADDR  = 5
) (
    input  logic             clk,
    input  logic             we,
    input  logic [ADDR-1:0]  addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [2**ADDR];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

>>> rtl/core/skte_cmp.sv
// Shared key compare unit: equality and sort-before.
module skte_cmp
    import skte_pkg::*;
(
    input  logic [KEY_BITS-1:0] a,
    input  logic [KEY_BITS-1:0] b,
    input  logic                desc,
    input  logic                sgn,
    output logic                eq,
    output logic                ahead
);

    logic [KEY_BITS-1:0] x;
    logic [KEY_BITS-1:0] y;

    always_comb
    begin
        x = a;
        y = b;
        x[KEY_BITS-1] = a[KEY_BITS-1] ^ sgn;
        y[KEY_BITS-1] = b[KEY_BITS-1] ^ sgn;
        eq    = (a == b);
        ahead = desc ? (x > y) : (x < y);
    end

endmodule

>>> rtl/core/sorted_key_table_engine_unit.sv
// Top level: sorted key table engine with sequencer, shared compare unit and RAMs.
//  channel | signals                                   | handshake
//  cmd in  | cmd key value index                       | start & !busy
//  result  | status key_out value_out position         | done strobe, one cycle
//          | record_count active_bank                  |
//  config  | cfg_index cfg_data                        | cfg_valid & cfg_ready
// Search reads one entry at a time through the key RAM port, alternating S_SRD and S_SCMP.
// Insert and delete then shift entries one at a time through the same port,
// alternating S_SHRD and S_SHWR.
// Reset clears counts, active bank and config flags and sets the capacity to 16; RAM contents are not cleared.
// The receiver cannot stall; done pulses for one cycle per command.
module sorted_key_table_engine_unit
    import skte_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  cmd,
    input  logic [31:0] key,
    input  logic [31:0] value,
    input  logic [4:0]  index,
    output logic        done,
    output logic [2:0]  status,
    output logic [31:0] key_out,
    output logic [31:0] value_out,
    output logic [4:0]  position,
    output logic [4:0]  record_count,
    output logic        active_bank,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [4:0]  cfg_data
);

    state_t state_reg, state_next;

    logic desc_reg, sgn_reg, dbank_reg;
    logic [4:0] cap_reg;
    logic [CW-1:0] cnt_reg [2];
    logic [CW-1:0] cnt_next [2];
    logic rb_reg, rb_next;

    cmd_t cmd_reg, cmd_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [4:0] idx_reg, idx_next;
    logic bank_reg, bank_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] bef_reg, bef_next;
    logic hit_reg, hit_next;
    logic [CW-1:0] p_reg, p_next;

    logic [2:0]  st_reg, st_next;
    logic [31:0] ko_reg, ko_next;
    logic [31:0] vo_reg, vo_next;
    logic [4:0]  pos_reg, pos_next;
    logic [4:0]  rc_reg, rc_next;
    logic        done_reg, done_next;

    logic            k_we, v_we;
    logic [AW-1:0]   k_addr, v_addr;
    logic [KEY_BITS-1:0] k_wd, k_rd;
    logic [VALUE_BITS-1:0] v_wd, v_rd;
    logic eq, ahead;
    logic [CW-1:0] limit;
    logic wb;
    logic [CW-1:0] n;

    skte_ram #(.WIDTH(KEY_BITS), .ADDR(AW)) u_kram (
        .clk(clk), .we(k_we), .addr(k_addr), .wdata(k_wd), .rdata(k_rd)
    );
    skte_ram #(.WIDTH(VALUE_BITS), .ADDR(AW)) u_vram (
        .clk(clk), .we(v_we), .addr(v_addr), .wdata(v_wd), .rdata(v_rd)
    );
    skte_cmp u_cmp (
        .a(k_rd), .b(key_reg), .desc(desc_reg), .sgn(sgn_reg),
        .eq(eq), .ahead(ahead)
    );

    function automatic logic [AW-1:0] mk_addr(input logic b, input logic [CW-1:0] p);
        logic [AW:0] t;
        t = (AW+1)'(b) * (AW+1)'(DEPTH) + (AW+1)'(p);
        return t[AW-1:0];
    endfunction

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign status    = st_reg;
    assign key_out   = ko_reg;
    assign value_out = vo_reg;
    assign position  = pos_reg;
    assign record_count = rc_reg;
    assign active_bank  = rb_reg;

    assign limit = (cap_reg > 5'(DEPTH)) ? CW'(DEPTH) : CW'(cap_reg);
    assign wb    = dbank_reg ? ~rb_reg : rb_reg;
    assign n     = cnt_reg[bank_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            desc_reg  <= 1'b0;
            sgn_reg   <= 1'b0;
            dbank_reg <= 1'b0;
            cap_reg   <= 5'd16;
            cnt_reg[0] <= '0;
            cnt_reg[1] <= '0;
            rb_reg    <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg[0] <= cnt_next[0];
            cnt_reg[1] <= cnt_next[1];
            rb_reg    <= rb_next;
            done_reg  <= done_next;
            if (cfg_valid)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_DESC:   desc_reg  <= cfg_data[0];
                    CFG_SIGNED: sgn_reg   <= cfg_data[0];
                    CFG_DBANK:  dbank_reg <= cfg_data[0];
                    CFG_CAP:    cap_reg   <= cfg_data;
                    default:    ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        key_reg <= key_next;
        val_reg <= val_next;
        idx_reg <= idx_next;
        bank_reg <= bank_next;
        i_reg   <= i_next;
        bef_reg <= bef_next;
        hit_reg <= hit_next;
        p_reg   <= p_next;
        st_reg  <= st_next;
        ko_reg  <= ko_next;
        vo_reg  <= vo_next;
        pos_reg <= pos_next;
        rc_reg  <= rc_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next[0] = cnt_reg[0];
        cnt_next[1] = cnt_reg[1];
        rb_next   = rb_reg;
        done_next = 1'b0;
        cmd_next = cmd_reg;
        key_next = key_reg;
        val_next = val_reg;
        idx_next = idx_reg;
        bank_next = bank_reg;
        i_next   = i_reg;
        bef_next = bef_reg;
        hit_next = hit_reg;
        p_next   = p_reg;
        st_next  = st_reg;
        ko_next  = ko_reg;
        vo_next  = vo_reg;
        pos_next = pos_reg;
        rc_next  = rc_reg;
        k_we = 1'b0;
        v_we = 1'b0;
        k_addr = mk_addr(bank_reg, i_reg);
        v_addr = mk_addr(bank_reg, i_reg);
        k_wd = key_reg;
        v_wd = val_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next = cmd_t'(cmd);
                    key_next = key;
                    val_next = value;
                    idx_next = index;
                    i_next   = '0;
                    bef_next = '0;
                    hit_next = 1'b0;
                    st_next  = ST_OK;
                    ko_next  = '0;
                    vo_next  = '0;
                    pos_next = '0;
                    case (cmd)
                        CMD_INSERT, CMD_UPDATE, CMD_DEL_KEY, CMD_DEL_1ST, CMD_TRUNC:
                            bank_next = wb;
                        default:
                            bank_next = rb_reg;
                    endcase
                    state_next = S_SRD;
                end
            end
            S_SRD:
            begin
                unique case (cmd_reg)
                    CMD_LOOKUP, CMD_INSERT, CMD_UPDATE, CMD_DEL_KEY:
                    begin
                        if (i_reg < n)
                        begin
                            state_next = S_SCMP;
                        end
                        else
                        begin
                            p_next = bef_reg;
                            state_next = S_DECIDE;
                        end
                    end
                    CMD_DEL_1ST:
                    begin
                        if (n != '0)
                        begin
                            hit_next = 1'b1;
                            p_next = '0;
                            state_next = S_DECIDE;
                        end
                        else
                        begin
                            st_next = ST_NOTFOUND;
                            state_next = S_DONE;
                        end
                    end
                    CMD_RD_IDX:
                    begin
                        if (idx_reg != 5'd0 && CW'(idx_reg) <= n)
                        begin
                            p_next = CW'(idx_reg - 5'd1);
                            hit_next = 1'b1;
                            state_next = S_DECIDE;
                        end
                        else
                        begin
                            st_next = ST_NOTFOUND;
                            state_next = S_DONE;
                        end
                    end
                    CMD_TRUNC:
                    begin
                        cnt_next[bank_reg] = '0;
                        state_next = S_DONE;
                    end
                    CMD_SWAP:
                    begin
                        if (dbank_reg)
                        begin
                            rb_next = ~rb_reg;
                            bank_next = ~rb_reg;
                        end
                        else
                        begin
                            st_next = ST_SWAP_REF;
                        end
                        state_next = S_DONE;
                    end
                    CMD_COUNT:
                        state_next = S_DONE;
                    default:
                    begin
                        st_next = ST_NOTFOUND;
                        state_next = S_DONE;
                    end
                endcase
            end
            S_SCMP:
            begin
                if (eq)
                begin
                    hit_next = 1'b1;
                    p_next = i_reg;
                    state_next = S_DECIDE;
                end
                else
                begin
                    if (ahead)
                    begin
                        bef_next = bef_reg + CW'(1);
                    end
                    i_next = i_reg + CW'(1);
                    state_next = S_SRD;
                end
            end
            S_DECIDE:
            begin
                pos_next = 5'(p_reg + CW'(1));
                i_next = p_reg;
                if (hit_reg)
                begin
                    if (cmd_reg == CMD_INSERT)
                    begin
                        st_next = ST_DUP;
                    end
                    state_next = S_RDREC;
                end
                else
                begin
                    unique case (cmd_reg)
                        CMD_INSERT:
                        begin
                            if (n >= limit)
                            begin
                                st_next = ST_FULL;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                ko_next = key_reg;
                                vo_next = val_reg;
                                i_next = n;
                                state_next = S_SHRD;
                            end
                        end
                        default:
                        begin
                            st_next = ST_NOTFOUND;
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_RDREC:
            begin
                if (cmd_reg == CMD_UPDATE)
                begin
                    v_we = 1'b1;
                end
                state_next = S_RDWAIT;
            end
            S_RDWAIT:
            begin
                ko_next = k_rd;
                vo_next = (cmd_reg == CMD_UPDATE) ? val_reg : v_rd;
                if (cmd_reg == CMD_DEL_KEY || cmd_reg == CMD_DEL_1ST)
                begin
                    i_next = p_reg + CW'(1);
                    state_next = S_SHRD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_SHRD:
            begin
                if (cmd_reg == CMD_INSERT)
                begin
                    if (i_reg > p_reg)
                    begin
                        k_addr = mk_addr(bank_reg, i_reg - CW'(1));
                        v_addr = k_addr;
                        state_next = S_SHWR;
                    end
                    else
                    begin
                        state_next = S_WRNEW;
                    end
                end
                else
                begin
                    if (i_reg < n)
                    begin
                        state_next = S_SHWR;
                    end
                    else
                    begin
                        cnt_next[bank_reg] = n - CW'(1);
                        state_next = S_DONE;
                    end
                end
            end
            S_SHWR:
            begin
                k_we = 1'b1;
                v_we = 1'b1;
                k_wd = k_rd;
                v_wd = v_rd;
                if (cmd_reg == CMD_INSERT)
                begin
                    i_next = i_reg - CW'(1);
                end
                else
                begin
                    k_addr = mk_addr(bank_reg, i_reg - CW'(1));
                    v_addr = k_addr;
                    i_next = i_reg + CW'(1);
                end
                state_next = S_SHRD;
            end
            S_WRNEW:
            begin
                k_we = 1'b1;
                v_we = 1'b1;
                cnt_next[bank_reg] = n + CW'(1);
                state_next = S_DONE;
            end
            S_DONE:
            begin
                rc_next = 5'(cnt_reg[bank_reg]);
                done_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule
